### rtl/postfix_stack_evaluator_defines.svh
// assertion macros for the postfix stack evaluator checker
// no dependencies; included by files that hold concurrent assertions
`ifndef POSTFIX_STACK_EVALUATOR_DEFINES_SVH
`define POSTFIX_STACK_EVALUATOR_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define PSE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pse assertion failed");

// next-cycle implication, disabled while reset is held
`define PSE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pse assertion failed");

`endif

### rtl/pse_pkg.sv
// shared types, codes and constants of the postfix stack evaluator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package pse_pkg;

    localparam int DEF_STACK_DEPTH = 16;
    localparam int DEF_WORD_WIDTH  = 32;

    localparam int CHAR_W   = 8;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;

    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DIVZERO   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FETCH,
        S_EXEC,
        S_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic                capture;
        logic                push;
        logic                set_err;
        logic [STATUS_W-1:0] err_code;
        logic                rd;
        logic                alu_start;
        logic                commit;
        logic                report;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic err_set;
        logic is_digit;
        logic is_op;
        logic is_div;
        logic full;
        logic lt2;
        logic tos_zero;
        logic last;
        logic alu_done;
        logic out_busy;
    } sts_t;

endpackage

`default_nettype wire

### rtl/pse_alu.sv
// iterative arithmetic unit: add/sub computed at start, radix-2 multiply and divide
// depends on pse_pkg
`timescale 1ns / 1ps
`default_nettype none

module pse_alu
    import pse_pkg::*;
#(
    parameter int WORD_WIDTH = DEF_WORD_WIDTH
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire op_t                   op,
    input  wire logic [WORD_WIDTH-1:0] left,
    input  wire logic [WORD_WIDTH-1:0] right,
    output logic                       done,
    output logic [WORD_WIDTH-1:0]      result
);

    localparam int CNT_W = $clog2(WORD_WIDTH + 1);

    logic [CNT_W-1:0]      cnt_reg;
    logic [WORD_WIDTH-1:0] a_reg;
    logic [WORD_WIDTH-1:0] b_reg;
    logic [WORD_WIDTH-1:0] r_reg;
    op_t                   op_reg;
    logic                  neg_reg;

    logic [WORD_WIDTH:0]   rem_shift;
    logic [WORD_WIDTH:0]   diff;
    logic                  qbit;
    logic [WORD_WIDTH-1:0] left_mag;
    logic [WORD_WIDTH-1:0] right_mag;

    assign left_mag  = left[WORD_WIDTH-1]  ? (~left + 1'b1)  : left;
    assign right_mag = right[WORD_WIDTH-1] ? (~right + 1'b1) : right;

    // restoring division step
    assign rem_shift = {r_reg, a_reg[WORD_WIDTH-1]};
    assign diff      = rem_shift - {1'b0, b_reg};
    assign qbit      = ~diff[WORD_WIDTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            if (op == OP_MUL || op == OP_DIV)
                cnt_reg <= CNT_W'(WORD_WIDTH);
            else
                cnt_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg  <= op;
            neg_reg <= left[WORD_WIDTH-1] ^ right[WORD_WIDTH-1];
            unique case (op)
                OP_ADD:
                begin
                    r_reg <= left + right;
                end
                OP_SUB:
                begin
                    r_reg <= left - right;
                end
                OP_MUL:
                begin
                    a_reg <= right;
                    b_reg <= left;
                    r_reg <= '0;
                end
                OP_DIV:
                begin
                    a_reg <= left_mag;
                    b_reg <= right_mag;
                    r_reg <= '0;
                end
                default:
                begin
                    r_reg <= '0;
                end
            endcase
        end
        else if (cnt_reg != '0)
        begin
            if (op_reg == OP_MUL)
            begin
                if (a_reg[0])
                    r_reg <= r_reg + b_reg;
                b_reg <= {b_reg[WORD_WIDTH-2:0], 1'b0};
                a_reg <= {1'b0, a_reg[WORD_WIDTH-1:1]};
            end
            else
            begin
                r_reg <= qbit ? diff[WORD_WIDTH-1:0] : rem_shift[WORD_WIDTH-1:0];
                a_reg <= {a_reg[WORD_WIDTH-2:0], qbit};
            end
        end
    end

    assign done   = (cnt_reg == '0);
    assign result = (op_reg == OP_DIV) ? (neg_reg ? (~a_reg + 1'b1) : a_reg) : r_reg;

endmodule

`default_nettype wire

### rtl/pse_datapath.sv
// datapath: operand stack with cached top, error register, alu, output register
// depends on pse_pkg and pse_alu
`timescale 1ns / 1ps
`default_nettype none

module pse_datapath
    import pse_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int WORD_WIDTH  = DEF_WORD_WIDTH
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cmd_t                cmd,
    output sts_t                     sts,
    input  wire logic [CHAR_W-1:0]   char_in,
    input  wire logic                last_in,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [VALUE_W-1:0]       m_tdata,
    output logic [STATUS_W-1:0]      m_tuser
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // entries below the top live in memory; the top lives in tos_reg
    logic [WORD_WIDTH-1:0] mem [STACK_DEPTH];

    logic [CNT_W-1:0]      count_reg;
    logic [STATUS_W-1:0]   err_reg;
    logic [CHAR_W-1:0]     char_reg;
    logic                  last_reg;
    logic [WORD_WIDTH-1:0] tos_reg;
    logic [WORD_WIDTH-1:0] rd_data_reg;
    logic                  out_valid_reg;
    logic [VALUE_W-1:0]    value_reg;
    logic [STATUS_W-1:0]   status_reg;

    logic                  is_digit;
    logic                  is_op;
    op_t                   op_sel;
    logic [WORD_WIDTH-1:0] digit_val;
    logic                  alu_done;
    logic [WORD_WIDTH-1:0] alu_result;
    logic [IDX_W-1:0]      wr_idx;
    logic [IDX_W-1:0]      rd_idx;

    assign is_digit  = (char_reg >= CH_ZERO) && (char_reg <= CH_NINE);
    assign digit_val = WORD_WIDTH'(char_reg - CH_ZERO);

    always_comb
    begin
        is_op  = 1'b1;
        op_sel = OP_ADD;
        unique case (char_reg)
            CH_PLUS:  op_sel = OP_ADD;
            CH_MINUS: op_sel = OP_SUB;
            CH_STAR:  op_sel = OP_MUL;
            CH_SLASH: op_sel = OP_DIV;
            default:  is_op  = 1'b0;
        endcase
    end

    assign wr_idx = IDX_W'(count_reg - CNT_W'(1));
    assign rd_idx = IDX_W'(count_reg - CNT_W'(2));

    pse_alu #(
        .WORD_WIDTH (WORD_WIDTH)
    ) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.alu_start),
        .op     (op_sel),
        .left   (rd_data_reg),
        .right  (tos_reg),
        .done   (alu_done),
        .result (alu_result)
    );

    // stack memory: one write and one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.push && count_reg != '0)
            mem[wr_idx] <= tos_reg;
        if (cmd.rd)
            rd_data_reg <= mem[rd_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.report)
            begin
                count_reg     <= '0;
                err_reg       <= ST_OK;
                out_valid_reg <= 1'b1;
            end
            else
            begin
                if (m_tready)
                    out_valid_reg <= 1'b0;
                if (cmd.set_err)
                    err_reg <= cmd.err_code;
                if (cmd.push)
                    count_reg <= count_reg + CNT_W'(1);
                else if (cmd.commit)
                    count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            char_reg <= char_in;
            last_reg <= last_in;
        end
        if (cmd.push)
            tos_reg <= digit_val;
        else if (cmd.commit)
            tos_reg <= alu_result;
        if (cmd.report)
        begin
            if (err_reg != ST_OK)
            begin
                value_reg  <= '0;
                status_reg <= err_reg;
            end
            else if (count_reg == '0)
            begin
                value_reg  <= '0;
                status_reg <= ST_EMPTY;
            end
            else
            begin
                value_reg  <= VALUE_W'($signed(tos_reg));
                status_reg <= ST_OK;
            end
        end
    end

    assign sts.err_set  = (err_reg != ST_OK);
    assign sts.is_digit = is_digit;
    assign sts.is_op    = is_op;
    assign sts.is_div   = (op_sel == OP_DIV);
    assign sts.full     = (count_reg == CNT_W'(STACK_DEPTH));
    assign sts.lt2      = (count_reg < CNT_W'(2));
    assign sts.tos_zero = (tos_reg == '0);
    assign sts.last     = last_reg;
    assign sts.alu_done = alu_done;
    assign sts.out_busy = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = value_reg;
    assign m_tuser  = status_reg;

endmodule

`default_nettype wire

### rtl/pse_ctrl.sv
// controller state machine: sequences decode, stack access, alu and report
// depends on pse_pkg
`timescale 1ns / 1ps
`default_nettype none

module pse_ctrl
    import pse_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic      s_tready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                if (!sts.err_set && !sts.is_digit && sts.is_op && !sts.lt2
                    && !(sts.is_div && sts.tos_zero))
                    state_next = S_FETCH;
                else
                    state_next = S_FINISH;
            end
            S_FETCH:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (sts.alu_done)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!(sts.last && sts.out_busy))
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            S_DECODE:
            begin
                if (!sts.err_set)
                begin
                    if (sts.is_digit)
                    begin
                        if (sts.full)
                        begin
                            cmd.set_err  = 1'b1;
                            cmd.err_code = ST_OVERFLOW;
                        end
                        else
                        begin
                            cmd.push = 1'b1;
                        end
                    end
                    else if (sts.is_op)
                    begin
                        if (sts.lt2)
                        begin
                            cmd.set_err  = 1'b1;
                            cmd.err_code = ST_UNDERFLOW;
                        end
                        else if (sts.is_div && sts.tos_zero)
                        begin
                            cmd.set_err  = 1'b1;
                            cmd.err_code = ST_DIVZERO;
                        end
                        else
                        begin
                            cmd.rd = 1'b1;
                        end
                    end
                end
            end
            S_FETCH:
            begin
                cmd.alu_start = 1'b1;
            end
            S_EXEC:
            begin
                cmd.commit = sts.alu_done;
            end
            S_FINISH:
            begin
                cmd.report = sts.last && !sts.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/postfix_stack_evaluator.sv
// top level of the postfix stack evaluator: controller plus datapath
// depends on pse_pkg, pse_ctrl, pse_datapath (and pse_alu below it)
//
// usage
//   slave channel: one expression character per request, s_tdata holds the byte,
//   s_tlast marks the last character of the expression
//   master channel: one result per expression, m_tdata is the top of the stack
//   (sign-extended or truncated to 32 bits), m_tuser the status code
//   (ok, underflow, divide by zero, overflow, empty); value is zero on any non-ok status
//   one character is in flight at a time; s_tready is high only while idle
//   states per character, from acceptance to the next acceptance:
//     digit, ignored byte or any byte after an error: idle, decode, finish
//     add or subtract: idle, decode, fetch, exec, finish
//     multiply or divide: as add or subtract, with exec held for the radix-2
//     shift-add / restoring iteration of the shared arithmetic unit
//   the result is registered onto m_tvalid once the last character finishes
//   a stalled result holds in the output register; a further character is still
//   taken, and only the next end of expression waits until the result is taken
//   reset clears stack count, error and output valid at once; no clearing pass
//
`timescale 1ns / 1ps
`default_nettype none

module postfix_stack_evaluator
    import pse_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int WORD_WIDTH  = DEF_WORD_WIDTH
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // character requests
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [CHAR_W-1:0]   s_tdata,   // [7:0] char_code
    input  wire logic                s_tlast,   // end_of_expression
    // result requests
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [VALUE_W-1:0]       m_tdata,   // [31:0] value
    output logic [STATUS_W-1:0]      m_tuser    // [2:0] status
);

    cmd_t cmd;
    sts_t sts;

    // sequencing: accept, decode, stack read, alu iterations, report
    pse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // stack, error state, arithmetic and output register
    pse_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .WORD_WIDTH  (WORD_WIDTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .char_in  (s_tdata),
        .last_in  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

### rtl/pse_checker.sv
// port-level checker for the postfix stack evaluator, bound to the top level
// depends on pse_pkg and postfix_stack_evaluator_defines.svh
`timescale 1ns / 1ps
`default_nettype none

`include "postfix_stack_evaluator_defines.svh"

module pse_checker
    import pse_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    input  wire logic                s_tready,
    input  wire logic                s_tlast,
    input  wire logic                m_tvalid,
    input  wire logic                m_tready,
    input  wire logic [VALUE_W-1:0]  m_tdata,
    input  wire logic [STATUS_W-1:0] m_tuser
);

    // a stalled result holds
    `PSE_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // status codes stay within the defined set
    `PSE_ASSERT_IMP(a_status_range, clk, rst_n, m_tvalid, m_tuser <= ST_EMPTY)

    // any failing status carries a zero value
    `PSE_ASSERT_IMP(a_err_zero, clk, rst_n, m_tvalid && m_tuser != ST_OK, m_tdata == '0)

    // a character that does not end the expression raises no result
    `PSE_ASSERT_NXT(a_no_spurious, clk, rst_n, s_tvalid && s_tready && !s_tlast && !m_tvalid, !m_tvalid)

    // only one character is in flight
    `PSE_ASSERT_NXT(a_one_in_flight, clk, rst_n, s_tvalid && s_tready, !s_tready)

endmodule

bind postfix_stack_evaluator pse_checker u_pse_checker (.*);

`default_nettype wire

### sim/tb.sv
// self-checking testbench for postfix_stack_evaluator: directed and random expressions
// depends on pse_pkg and the evaluator rtl; a scoreboard class predicts each result
`timescale 1ns / 1ps

module tb;
    import pse_pkg::*;

    localparam int          HALF_PERIOD   = 6;
    localparam int          RANDOM_ITEMS  = 390;
    localparam int          CALM_ITEMS    = 340;   // no idling past this point
    localparam int          QUIET_LIMIT   = 4000;
    localparam int          TAIL_CYCLES   = 60;
    localparam logic [CHAR_W-1:0] OPERATORS [4] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
    } eval_result_t;

    // mirrors the evaluator: operand stack, count and sticky error
    class postfix_scoreboard;
        logic [VALUE_W-1:0]  operands [DEF_STACK_DEPTH];
        int unsigned         depth;
        logic [STATUS_W-1:0] err;
        eval_result_t        results_due [$];
        int unsigned         errors;

        function new();
            depth  = 0;
            err    = ST_OK;
            errors = 0;
        endfunction

        function int unsigned pending();
            return results_due.size();
        endfunction

        function void note_char(input logic [CHAR_W-1:0] ch, input logic last);
            logic [VALUE_W-1:0] lhs;
            logic [VALUE_W-1:0] rhs;
            logic [VALUE_W-1:0] res;
            logic [VALUE_W-1:0] mag_l;
            logic [VALUE_W-1:0] mag_r;
            logic [VALUE_W-1:0] quo;
            eval_result_t       outcome;
            if (err == ST_OK)
            begin
                if (ch >= CH_ZERO && ch <= CH_NINE)
                begin
                    if (depth >= DEF_STACK_DEPTH)
                        err = ST_OVERFLOW;
                    else
                    begin
                        operands[depth] = VALUE_W'(ch - CH_ZERO);
                        depth++;
                    end
                end
                else if (ch == CH_PLUS || ch == CH_MINUS || ch == CH_STAR || ch == CH_SLASH)
                begin
                    if (depth < 2)
                        err = ST_UNDERFLOW;
                    else
                    begin
                        rhs = operands[depth - 1];
                        lhs = operands[depth - 2];
                        res = '0;
                        case (ch)
                            CH_PLUS:  res = lhs + rhs;
                            CH_MINUS: res = lhs - rhs;
                            CH_STAR:  res = lhs * rhs;
                            default:
                            begin
                                if (rhs == '0)
                                    err = ST_DIVZERO;
                                else
                                begin
                                    // unsigned divide of magnitudes, sign applied after;
                                    // most negative over minus one wraps to itself
                                    mag_l = lhs[VALUE_W-1] ? -lhs : lhs;
                                    mag_r = rhs[VALUE_W-1] ? -rhs : rhs;
                                    quo   = mag_l / mag_r;
                                    res   = (lhs[VALUE_W-1] ^ rhs[VALUE_W-1]) ? -quo : quo;
                                end
                            end
                        endcase
                        if (err == ST_OK)
                        begin
                            depth--;
                            operands[depth - 1] = res;
                        end
                    end
                end
            end
            if (last)
            begin
                outcome.value = '0;
                if (err != ST_OK)
                    outcome.status = err;
                else if (depth == 0)
                    outcome.status = ST_EMPTY;
                else
                begin
                    outcome.status = ST_OK;
                    outcome.value  = operands[depth - 1];
                end
                results_due.push_back(outcome);
                depth = 0;
                err   = ST_OK;
            end
        endfunction

        function void check_result(input logic [VALUE_W-1:0] value,
                                   input logic [STATUS_W-1:0] status);
            eval_result_t want;
            if (results_due.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual value %0d status %0d",
                         $time, $signed(value), status);
                errors++;
                return;
            end
            want = results_due.pop_front();
            if (value !== want.value)
            begin
                $display("%0t: value mismatch, expected %0d, actual %0d",
                         $time, $signed(want.value), $signed(value));
                errors++;
            end
            if (status !== want.status)
            begin
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, want.status, status);
                errors++;
            end
        endfunction
    endclass

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [CHAR_W-1:0]   s_tdata  = '0;
    logic                s_tlast  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [VALUE_W-1:0]  m_tdata;
    logic [STATUS_W-1:0] m_tuser;

    postfix_scoreboard sb = new();
    bit                idle_on     = 1'b1;
    int unsigned       items_sent  = 0;
    int unsigned       stall_left  = 0;
    int unsigned       quiet_count = 0;

    postfix_stack_evaluator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic bit is_token(input logic [CHAR_W-1:0] ch);
        return (ch >= CH_ZERO && ch <= CH_NINE) ||
               ch == CH_PLUS || ch == CH_MINUS || ch == CH_STAR || ch == CH_SLASH;
    endfunction

    function automatic logic [CHAR_W-1:0] pick_ignored();
        logic [CHAR_W-1:0] ch;
        ch = CHAR_W'($urandom_range(0, 255));
        while (is_token(ch))
            ch = CHAR_W'($urandom_range(0, 255));
        return ch;
    endfunction

    // result side: random stall bursts while idling is on
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (rst_n && idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 10);
            m_tready   <= 1'b0;
        end
        else
            m_tready <= rst_n;
    end

    // handshake monitor and watchdog; results are checked before new characters are noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser);
            if (s_tvalid && s_tready)
                sb.note_char(s_tdata, s_tlast);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                quiet_count = 0;
            else
                quiet_count++;
            if (quiet_count >= QUIET_LIMIT)
            begin
                $display("%0t: no request moved for %0d cycles", $time, QUIET_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic send_char(input logic [CHAR_W-1:0] ch, input logic last);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 11);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_text(input string txt);
        for (int k = 0; k < txt.len(); k++)
            send_char(txt[k], k == txt.len() - 1);
    endtask

    // hold off the sender until every pending result has been taken
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // mostly well-formed expressions, some broken token runs, some raw byte noise
    task automatic send_random_expression();
        logic [CHAR_W-1:0] text [$];
        int unsigned       kind;
        int unsigned       count;
        int unsigned       depth;
        bit                deep;
        kind = $urandom_range(0, 99);
        if (kind < 70)
        begin
            deep  = ($urandom_range(0, 9) == 0);
            count = deep ? $urandom_range(12, 18) : $urandom_range(1, 6);
            depth = 0;
            for (int unsigned k = 0; k < count; k++)
            begin
                text.push_back(CHAR_W'(CH_ZERO + $urandom_range(0, 9)));
                depth++;
                while (!deep && depth >= 2 && $urandom_range(0, 1) == 1)
                begin
                    text.push_back(OPERATORS[$urandom_range(0, 3)]);
                    depth--;
                end
                if ($urandom_range(0, 9) == 0)
                    text.push_back(pick_ignored());
            end
            while (depth > 1)
            begin
                text.push_back(OPERATORS[$urandom_range(0, 3)]);
                depth--;
            end
        end
        else if (kind < 85)
        begin
            repeat ($urandom_range(1, 8))
                text.push_back($urandom_range(0, 1) ? CHAR_W'(CH_ZERO + $urandom_range(0, 9))
                                                    : OPERATORS[$urandom_range(0, 3)]);
        end
        else
        begin
            repeat ($urandom_range(1, 6))
                text.push_back(CHAR_W'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 9) == 0)
            text.push_back(pick_ignored());
        foreach (text[k])
            send_char(text[k], k == text.size() - 1);
    endtask

    initial
    begin
        int unsigned random_base;
        bit          paused;
        paused = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every operator, both digit extremes, negative quotient truncated toward zero
        send_text("09-2/3*4+");
        // one operand then an operator: underflow, the later digit is ignored
        send_text("5+7");
        // divide by zero reported, the later add is not carried out
        send_text("50/9+");
        // ignored bytes only: empty stack at the end
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b1);
        // seventeenth digit overflows the stack
        send_text("99999999999999990");
        // build the most negative value and divide it by minus one
        send_text("8888888888*********2*01-/");
        wait_drained();

        random_base = items_sent;
        while (items_sent - random_base < RANDOM_ITEMS)
        begin
            if (items_sent - random_base >= CALM_ITEMS)
                idle_on = 1'b0;
            if (!paused && items_sent - random_base >= RANDOM_ITEMS / 2)
            begin
                wait_drained();
                paused = 1'b1;
            end
            send_random_expression();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            $display("%0t: %0d results expected but never seen", $time, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
